### src/fmpf_pkg.sv
// ----------------------------------------------------------------------------
// fmpf_pkg
// Shared constants, codes, word layouts and helpers of the packet filter.
// ----------------------------------------------------------------------------
package fmpf_pkg;

   localparam int MAX_RULES   = 16;
   localparam int ADDR_W      = 32;
   localparam int PROTO_W     = 8;
   localparam int PORT_W      = 16;
   localparam int IDX_W       = 4;
   localparam int TOTAL_W     = 5;
   localparam int CNT_W       = $clog2(MAX_RULES + 1);
   localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int GROUP_W     = 4;
   localparam int NUM_GROUPS  = (MAX_RULES + GROUP_W - 1) / GROUP_W;
   localparam int PAD_W       = NUM_GROUPS * GROUP_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   localparam logic [PROTO_W-1:0] PROTO_ANY = PROTO_W'(0);

   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_ADD    = 2'd1,
      OP_DELETE = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic {
      REG_DEFAULT_VERDICT = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  src_netmask;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ADDR_W-1:0]  dst_netmask;
      logic [PROTO_W-1:0] proto;
      logic [PORT_W-1:0]  port_low;
      logic [PORT_W-1:0]  port_high;
      logic               verdict;
   } rule_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  dst_addr;
      logic [PROTO_W-1:0] proto;
      logic [PORT_W-1:0]  port;
   } pkt_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic live;
   } cell_ctl_type;

   typedef struct packed {
      logic found;
      logic verdict;
   } pick_type;

   // Lowest set hit of a group wins.
   function automatic pick_type first_hit(input logic [GROUP_W-1:0] hits,
                                          input logic [GROUP_W-1:0] verdicts);
      pick_type res;
      res = '0;
      for (int k = GROUP_W - 1; k >= 0; k--) begin
         if (hits[k]) begin
            res.found   = 1'b1;
            res.verdict = verdicts[k];
         end
      end
      return res;
   endfunction

endpackage

### src/fmpf_if.sv
// ----------------------------------------------------------------------------
// fmpf_req_if / fmpf_rsp_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface fmpf_req_if;
   import fmpf_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [ADDR_W-1:0]  src_addr;
   logic [ADDR_W-1:0]  src_netmask;
   logic [ADDR_W-1:0]  dst_addr;
   logic [ADDR_W-1:0]  dst_netmask;
   logic [PROTO_W-1:0] proto_num;
   logic [PORT_W-1:0]  port_low;
   logic [PORT_W-1:0]  port_high;
   logic               rule_verdict_in;
   logic [IDX_W-1:0]   rule_index;

   modport source (output valid, req_type, src_addr, src_netmask, dst_addr, dst_netmask,
                   proto_num, port_low, port_high, rule_verdict_in, rule_index,
                   input ready);
   modport sink (input valid, req_type, src_addr, src_netmask, dst_addr, dst_netmask,
                 proto_num, port_low, port_high, rule_verdict_in, rule_index,
                 output ready);
endinterface

interface fmpf_rsp_if;
   import fmpf_pkg::*;
   logic               valid;
   logic               ready;
   logic               verdict;
   logic               status;
   logic [TOTAL_W-1:0] rule_total;

   modport source (output valid, verdict, status, rule_total, input ready);
   modport sink (input valid, verdict, status, rule_total, output ready);
endinterface

### src/fmpf_cell.sv
// ----------------------------------------------------------------------------
// fmpf_cell
// One rule slot: holds a rule, loads or shifts from its neighbor, flags a hit.
// ----------------------------------------------------------------------------
module fmpf_cell (
   input  logic                  clock,
   input  fmpf_pkg::rule_type     load_rule,
   input  fmpf_pkg::rule_type     next_rule,
   input  fmpf_pkg::cell_ctl_type ctl,
   input  fmpf_pkg::pkt_type      pkt,
   output fmpf_pkg::rule_type     rule_out,
   output logic                  hit_out
);
   import fmpf_pkg::*;

   rule_type rule_ff, rule_in;
   logic     hit_ff, hit_in;
   logic     proto_ok, src_ok, dst_ok, port_ok;

   always_comb begin
      priority if (ctl.load) begin
         rule_in = load_rule;
      end else if (ctl.shift) begin
         rule_in = next_rule;
      end else begin
         rule_in = rule_ff;
      end
   end

   // compare the held packet against this slot
   always_comb begin
      proto_ok = (rule_ff.proto == PROTO_ANY) || (rule_ff.proto == pkt.proto);
      src_ok   = ((pkt.src_addr ^ rule_ff.src_addr) & rule_ff.src_netmask) == '0;
      dst_ok   = ((pkt.dst_addr ^ rule_ff.dst_addr) & rule_ff.dst_netmask) == '0;
      port_ok  = (rule_ff.port_high == '0) ||
                 ((pkt.port >= rule_ff.port_low) && (pkt.port <= rule_ff.port_high));
      hit_in   = ctl.live && proto_ok && src_ok && dst_ok && port_ok;
   end

   always_ff @(posedge clock) begin
      rule_ff <= rule_in;
      hit_ff  <= hit_in;
   end

   assign rule_out = rule_ff;
   assign hit_out  = hit_ff;

endmodule

### src/fmpf_csr.sv
// ----------------------------------------------------------------------------
// fmpf_csr
// APB register file holding the no-match verdict.
// ----------------------------------------------------------------------------
module fmpf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fmpf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fmpf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fmpf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic                            default_verdict
);
   import fmpf_pkg::*;

   logic default_ff, default_in;
   logic sel_default;

   assign sel_default = (reg_index_type'(paddr[CSR_IDX_BIT]) == REG_DEFAULT_VERDICT);

   always_comb begin
      default_in = default_ff;
      if (psel && penable && pwrite && sel_default) begin
         default_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= 1'b0;
      end else begin
         default_ff <= default_in;
      end
   end

   assign prdata          = sel_default ? CSR_DATA_W'(default_ff) : '0;
   assign pready          = 1'b1;
   assign default_verdict = default_ff;

endmodule

### src/first_match_packet_filter.sv
// ----------------------------------------------------------------------------
// first_match_packet_filter
// Ordered rule table: check, append, delete with shift-down, flush.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          carries
//  req_chan  in         valid/ready        one request word (op + rule/packet)
//  rsp_chan  out        valid/ready        verdict, status, rule_total
//  APB       in         psel/penable/...   default_verdict at byte address 0
//
//  Flow: an accepted word passes the slot compare, the first-hit group stage
//  and the final pick into the output register, in that order; the next word
//  is taken only once the last result is in the output register, so one word
//  is in flight at a time. The compare stage of the cell row and the two-level
//  first-hit pick make up that path.
//  Reset: synchronous; clears the rule count and the handshake state. Slot
//  contents are not cleared, only slots below the count ever take part.
//  Stalls: a result held by rsp_chan.ready waits in the output register while
//  the next word is accepted and worked; only the final pick waits for it.
//
module first_match_packet_filter (
   input  logic                            clock,
   input  logic                            reset,
   fmpf_req_if.sink                        req_chan,
   fmpf_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fmpf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fmpf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fmpf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import fmpf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HIT,
      ST_GROUP,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   op_type              op_ff, op_in;
   logic                status_ff, status_in;
   pkt_type             pkt_ff, pkt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_verdict_ff, rsp_verdict_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   pick_type            grp_ff [NUM_GROUPS];
   pick_type            grp_in [NUM_GROUPS];

   logic                default_verdict;
   logic                req_fire;
   op_type              req_op;
   rule_type            new_rule;
   logic                add_ok, del_ok;
   logic [CMP_W-1:0]    idx_ext, cnt_ext;
   rule_type            slot_rule [MAX_RULES];
   cell_ctl_type        slot_ctl  [MAX_RULES];
   logic [MAX_RULES-1:0] hit_vec, verdict_vec;
   logic [PAD_W-1:0]    hit_pad, verdict_pad;
   pick_type            final_pick;

   fmpf_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .default_verdict (default_verdict)
   );

   // Request decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_op         = op_type'(req_chan.req_type);
   assign idx_ext        = CMP_W'(req_chan.rule_index);
   assign cnt_ext        = CMP_W'(count_ff);
   assign add_ok         = (count_ff != CNT_W'(MAX_RULES));
   assign del_ok         = (idx_ext < cnt_ext);

   always_comb begin
      new_rule.src_addr    = req_chan.src_addr;
      new_rule.src_netmask = req_chan.src_netmask;
      new_rule.dst_addr    = req_chan.dst_addr;
      new_rule.dst_netmask = req_chan.dst_netmask;
      new_rule.proto       = req_chan.proto_num;
      new_rule.port_low    = req_chan.port_low;
      new_rule.port_high   = req_chan.port_high;
      new_rule.verdict     = req_chan.rule_verdict_in;
      pkt_in.src_addr      = req_chan.src_addr;
      pkt_in.dst_addr      = req_chan.dst_addr;
      pkt_in.proto         = req_chan.proto_num;
      pkt_in.port          = req_chan.port_low;
   end

   // Row of rule slots. An append writes the slot at the count; a delete
   // shifts every slot from the index upward down by one, all in the
   // accepting cycle. The top slot refills from itself; it drops out of the
   // live range anyway.
   for (genvar i = 0; i < MAX_RULES; i++) begin : g_slot
      always_comb begin
         slot_ctl[i].load  = req_fire && (req_op == OP_ADD) && add_ok &&
                             (count_ff == CNT_W'(i));
         slot_ctl[i].shift = req_fire && (req_op == OP_DELETE) && del_ok &&
                             (CMP_W'(i) >= idx_ext);
         slot_ctl[i].live  = (CNT_W'(i) < count_ff);
      end

      fmpf_cell u_cell (
         .clock     (clock),
         .load_rule (new_rule),
         .next_rule ((i == MAX_RULES - 1) ? slot_rule[i] : slot_rule[(i + 1) % MAX_RULES]),
         .ctl       (slot_ctl[i]),
         .pkt       (pkt_ff),
         .rule_out  (slot_rule[i]),
         .hit_out   (hit_vec[i])
      );

      assign verdict_vec[i] = slot_rule[i].verdict;
   end

   // First-hit pick, stage one: lowest hit inside each group of slots
   assign hit_pad     = PAD_W'(hit_vec);
   assign verdict_pad = PAD_W'(verdict_vec);

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      assign grp_in[g] = first_hit(hit_pad[g*GROUP_W +: GROUP_W],
                                   verdict_pad[g*GROUP_W +: GROUP_W]);
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   // Stage two: lowest group with a hit, else the configured default
   always_comb begin
      final_pick.found   = 1'b0;
      final_pick.verdict = default_verdict;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_ff[g].found) begin
            final_pick = grp_ff[g];
         end
      end
   end

   // Sequencer and output register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_total_in   = rsp_total_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in  = ST_HIT;
               op_in     = req_op;
               status_in = 1'b0;
               unique case (req_op)
                  OP_CHECK: begin
                  end
                  OP_ADD: begin
                     if (add_ok) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (del_ok) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  OP_FLUSH: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_HIT: begin
            state_in = ST_GROUP;
         end
         ST_GROUP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = (op_ff == OP_CHECK) ? final_pick.verdict : 1'b0;
               rsp_status_in  = status_ff;
               rsp_total_in   = TOTAL_W'(count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      status_ff      <= status_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_total_ff   <= rsp_total_in;
      if (req_fire) begin
         pkt_ff <= pkt_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.verdict    = rsp_verdict_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.rule_total = rsp_total_ff;

endmodule

### src/fmpf_checker.sv
// ----------------------------------------------------------------------------
// fmpf_checker
// Port-level checks on the packet filter, bound to the top level.
// ----------------------------------------------------------------------------
module fmpf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        verdict,
   input logic                        status,
   input logic [fmpf_pkg::TOTAL_W-1:0] rule_total
);
   import fmpf_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(verdict) &&
                                  $stable(status) && $stable(rule_total))
      else $error("result word changed while stalled");

   // count never exceeds the table size
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TOTAL_W + 1)'(rule_total) <= (TOTAL_W + 1)'(MAX_RULES))
      else $error("rule_total beyond table size");

   // one word in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word in flight");

endmodule

bind first_match_packet_filter fmpf_checker u_fmpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .verdict    (rsp_chan.verdict),
   .status     (rsp_chan.status),
   .rule_total (rsp_chan.rule_total)
);

### sim/first_match_packet_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_match_packet_filter_test
// Self-checking bench for the ordered-rule packet filter. A directed table
// covers empty-table checks, bad delete indexes, a full table, inverted port
// ranges and field extremes. Random traffic follows, biased toward rules and
// packets that share addresses, protocols and ports so that first-match
// ordering, shift-down deletes and flushes are exercised. Every result word
// is compared against a local model of the rule table or a hand-written result.
// ----------------------------------------------------------------------------
module first_match_packet_filter_test;
   import fmpf_pkg::*;

   localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 12;     // settle time after the last result
   localparam int MAX_REPORTS  = 10;
   localparam logic [CSR_ADDR_W-1:0] DEFAULT_VERDICT_ADDR =
      CSR_ADDR_W'(4 * int'(REG_DEFAULT_VERDICT));

   localparam logic [PORT_W-1:0]  SERVICE_PORTS [6] = '{16'd0, 16'd22, 16'd53, 16'd80,
                                                        16'd443, 16'hFFFF};
   localparam logic [PROTO_W-1:0] COMMON_PROTOS [4] = '{8'd1, 8'd6, 8'd17, 8'hFF};

   // One request word as the filter sees it.
   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  src_netmask;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ADDR_W-1:0]  dst_netmask;
      logic [PROTO_W-1:0] proto;
      logic [PORT_W-1:0]  port_low;
      logic [PORT_W-1:0]  port_high;
      logic               rule_verdict;
      logic [IDX_W-1:0]   rule_index;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic               verdict;
      logic               status;
      logic [TOTAL_W-1:0] total;
   } outcome_type;

   // Directed row: the word, how many times to send it, and the result when
   // it is obvious enough to spell out here.
   typedef struct {
      req_word_type word;
      int           reps;
      bit           known;
      outcome_type  outcome;
   } plan_row_type;

   typedef struct {
      bit          known;
      outcome_type outcome;
   } typed_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fmpf_req_if req_bus ();
   fmpf_rsp_if rsp_bus ();

   first_match_packet_filter u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Local copy of the rule table and the default verdict
   // -------------------------------------------------------------------------
   rule_type    rule_tbl [MAX_RULES];
   int unsigned rule_cnt;
   logic        dflt_verdict;

   outcome_type      pending_outcomes [$];   // results still owed by the filter
   typed_result_type typed_results [$];      // hand-written results of directed rows
   plan_row_type     plan [$];

   int unsigned mismatches;
   int unsigned idle_cycles;
   int unsigned gap_pct;                  // chance of a sender gap per word
   int unsigned gen_cnt;                  // rule count as the stimulus sees it
   int          ready_hold;
   logic        calm;                     // no idling on either side
   logic [ADDR_W-1:0] addr_pool [6];

   function automatic void report_mismatch(string what, longint unsigned want,
                                           longint unsigned got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
   endfunction

   // Apply one accepted word to the table copy and return the result it owes.
   function automatic outcome_type apply_request(req_word_type w);
      outcome_type r;
      rule_type    ru;
      r = '0;
      case (w.op)
         OP_CHECK: begin
            r.verdict = dflt_verdict;
            // walk rules in order, first hit wins
            for (int k = 0; k < int'(rule_cnt); k++) begin
               ru = rule_tbl[k];
               if ((ru.proto == PROTO_ANY || ru.proto == w.proto) &&
                   ((w.src_addr ^ ru.src_addr) & ru.src_netmask) == '0 &&
                   ((w.dst_addr ^ ru.dst_addr) & ru.dst_netmask) == '0 &&
                   (ru.port_high == '0 ||
                    (w.port_low >= ru.port_low && w.port_low <= ru.port_high))) begin
                  r.verdict = ru.verdict;
                  break;
               end
            end
         end
         OP_ADD: begin
            if (rule_cnt >= MAX_RULES) begin
               r.status = 1'b1;
            end else begin
               rule_tbl[rule_cnt] = '{src_addr: w.src_addr, src_netmask: w.src_netmask,
                                      dst_addr: w.dst_addr, dst_netmask: w.dst_netmask,
                                      proto: w.proto, port_low: w.port_low,
                                      port_high: w.port_high, verdict: w.rule_verdict};
               rule_cnt++;
            end
         end
         OP_DELETE: begin
            if (w.rule_index >= rule_cnt) begin
               r.status = 1'b1;
            end else begin
               // close the gap: later rules move down one slot
               for (int k = w.rule_index; k + 1 < int'(rule_cnt); k++)
                  rule_tbl[k] = rule_tbl[k + 1];
               rule_cnt--;
            end
         end
         OP_FLUSH: rule_cnt = 0;
      endcase
      r.total = TOTAL_W'(rule_cnt);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Monitor: predict on every accepted request word, check every result word,
   // and end the run when the handshakes stop moving.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_word_type     w;
      outcome_type      got;
      outcome_type      want;
      typed_result_type typed;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            w = '{op: op_type'(req_bus.req_type), src_addr: req_bus.src_addr,
                  src_netmask: req_bus.src_netmask, dst_addr: req_bus.dst_addr,
                  dst_netmask: req_bus.dst_netmask, proto: req_bus.proto_num,
                  port_low: req_bus.port_low, port_high: req_bus.port_high,
                  rule_verdict: req_bus.rule_verdict_in, rule_index: req_bus.rule_index};
            want = apply_request(w);
            // a hand-written result, where the directed table has one, takes
            // the place of the predicted one
            if (typed_results.size() != 0) begin
               typed = typed_results.pop_front();
               if (typed.known)
                  want = typed.outcome;
            end
            pending_outcomes.push_back(want);
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{verdict: rsp_bus.verdict, status: rsp_bus.status,
                    total: rsp_bus.rule_total};
            if (pending_outcomes.size() == 0) begin
               report_mismatch("stray result word {verdict,status,total}", 0, got);
            end else begin
               want = pending_outcomes.pop_front();
               if (got.verdict !== want.verdict)
                  report_mismatch("verdict", want.verdict, got.verdict);
               if (got.status !== want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.total !== want.total)
                  report_mismatch("rule_total", want.total, got.total);
            end
         end

         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (psel && penable)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("first_match_packet_filter test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result-side backpressure: random stalls between stretches of ready;
   // none once the run goes calm.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_hold    <= 0;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_bus.ready && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold    <= $urandom_range(0, 15);
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold    <= $urandom_range(0, 24);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Drive one word and hold it until the filter takes it. A random gap may
   // come first; valid stays high from one word to the next otherwise.
   task automatic send_word(input req_word_type w);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.req_type        <= w.op;
      req_bus.src_addr        <= w.src_addr;
      req_bus.src_netmask     <= w.src_netmask;
      req_bus.dst_addr        <= w.dst_addr;
      req_bus.dst_netmask     <= w.dst_netmask;
      req_bus.proto_num       <= w.proto;
      req_bus.port_low        <= w.port_low;
      req_bus.port_high       <= w.port_high;
      req_bus.rule_verdict_in <= w.rule_verdict;
      req_bus.rule_index      <= w.rule_index;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Write default_verdict, read it back, and update the local copy.
   task automatic program_default_verdict(input logic v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= DEFAULT_VERDICT_ADDR;
      pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      dflt_verdict = v;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[0] !== v)
         report_mismatch("default_verdict read-back", v, prdata[0]);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] prefix_mask(int len);
      return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
   endfunction

   function automatic plan_row_type row(op_type op, logic [31:0] sa, logic [31:0] sm,
                                        logic [31:0] da, logic [31:0] dm, logic [7:0] pr,
                                        logic [15:0] plo, logic [15:0] phi, logic rv,
                                        logic [3:0] idx, int reps, int known,
                                        int ev, int es, int et);
      plan_row_type p;
      p.word    = '{op: op, src_addr: sa, src_netmask: sm, dst_addr: da, dst_netmask: dm,
                    proto: pr, port_low: plo, port_high: phi, rule_verdict: rv,
                    rule_index: idx};
      p.reps    = reps;
      p.known   = (known != 0);
      p.outcome = '{verdict: 1'(ev), status: 1'(es), total: TOTAL_W'(et)};
      return p;
   endfunction

   // Random word. Rules and packets draw from shared pools of addresses,
   // protocols and ports so that checks hit rules often; the rest is noise.
   function automatic req_word_type random_word(int unsigned add_pct);
      req_word_type w;
      int unsigned  pick;
      int           lo;
      int           hi;
      w = '{op: OP_CHECK, src_addr: $urandom, src_netmask: $urandom, dst_addr: $urandom,
            dst_netmask: $urandom, proto: PROTO_W'($urandom),
            port_low: PORT_W'($urandom), port_high: PORT_W'($urandom),
            rule_verdict: 1'($urandom), rule_index: IDX_W'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 82 - add_pct)
         w.op = OP_CHECK;
      else if (pick < 82)
         w.op = OP_ADD;
      else if (pick < 97)
         w.op = OP_DELETE;
      else
         w.op = OP_FLUSH;

      case (w.op)
         OP_CHECK: begin
            // packet near a pooled address: flip a few low bits
            if ($urandom_range(0, 4) != 0) begin
               w.src_addr = addr_pool[$urandom_range(0, 5)] ^
                            (~prefix_mask($urandom_range(20, 32)) & $urandom);
               w.dst_addr = addr_pool[$urandom_range(0, 5)] ^
                            (~prefix_mask($urandom_range(20, 32)) & $urandom);
            end
            if ($urandom_range(0, 3) != 0)
               w.proto = COMMON_PROTOS[$urandom_range(0, 3)];
            if ($urandom_range(0, 3) != 0)
               w.port_low = PORT_W'(SERVICE_PORTS[$urandom_range(0, 5)] +
                                    $urandom_range(0, 2));
         end
         OP_ADD: begin
            w.src_addr = addr_pool[$urandom_range(0, 5)];
            w.dst_addr = addr_pool[$urandom_range(0, 5)];
            pick = $urandom_range(0, 9);
            if (pick == 1)
               w.src_netmask = '1;
            else if (pick > 1)
               w.src_netmask = prefix_mask($urandom_range(0, 32));
            pick = $urandom_range(0, 9);
            if (pick == 1)
               w.dst_netmask = '1;
            else if (pick > 1)
               w.dst_netmask = prefix_mask($urandom_range(0, 32));
            pick = $urandom_range(0, 9);
            if (pick < 3)
               w.proto = PROTO_ANY;
            else if (pick < 8)
               w.proto = COMMON_PROTOS[$urandom_range(0, 3)];
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               w.port_high = '0;
            end else if (pick == 3) begin
               // inverted range: never matches
               lo          = int'($urandom_range(2, 65535));
               hi          = int'($urandom_range(1, lo - 1));
               w.port_low  = PORT_W'(lo);
               w.port_high = PORT_W'(hi);
            end else if (pick < 9) begin
               lo = int'(SERVICE_PORTS[$urandom_range(0, 5)]) - int'($urandom_range(0, 20));
               if (lo < 0)
                  lo = 0;
               hi = lo + int'($urandom_range(0, 300));
               if (hi > 65535)
                  hi = 65535;
               w.port_low  = PORT_W'(lo);
               w.port_high = PORT_W'(hi);
            end
            if (gen_cnt < MAX_RULES)
               gen_cnt++;
         end
         OP_DELETE: begin
            if (gen_cnt != 0 && $urandom_range(0, 4) != 0)
               w.rule_index = IDX_W'($urandom_range(0, gen_cnt - 1));
            if (w.rule_index < gen_cnt)
               gen_cnt--;
         end
         OP_FLUSH: gen_cnt = 0;
      endcase
      return w;
   endfunction

   task automatic run_random(input int unsigned words, input int unsigned add_pct);
      for (int n = 0; n < int'(words); n++) begin
         // change the sender's idling every 64 words; calm means none
         if (n % 64 == 0)
            gap_pct = calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 :
                                  ($urandom_range(0, 1) == 0) ? 10 : 35);
         send_word(random_word(add_pct));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      req_word_type w;
      req_bus.valid           = 1'b0;
      req_bus.req_type        = OP_CHECK;
      req_bus.src_addr        = '0;
      req_bus.src_netmask     = '0;
      req_bus.dst_addr        = '0;
      req_bus.dst_netmask     = '0;
      req_bus.proto_num       = '0;
      req_bus.port_low        = '0;
      req_bus.port_high       = '0;
      req_bus.rule_verdict_in = 1'b0;
      req_bus.rule_index      = '0;
      rsp_bus.ready           = 1'b0;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b0;
      paddr                   = '0;
      pwdata                  = '0;
      calm                    = 1'b0;
      mismatches              = 0;
      idle_cycles             = 0;
      rule_cnt                = 0;
      dflt_verdict            = 1'b0;
      gen_cnt                 = 0;
      gap_pct                 = 20;
      foreach (addr_pool[i])
         addr_pool[i] = $urandom;

      // Directed table. Hand-written results where they are plain; rows with
      // zero in the known column are predicted instead.
      // op         src_addr      src_netmask   dst_addr      dst_netmask   proto
      //            port_low port_high  verdict  index   reps  known verdict status total
      plan.push_back(row(OP_CHECK,  32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 1, 1, 0, 0));  // empty: default
      plan.push_back(row(OP_CHECK,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
                         16'hFFFF, 16'hFFFF, 1'b1, 4'hF,  1, 1, 1, 0, 0));
      plan.push_back(row(OP_DELETE, 32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 1, 0, 1, 0));  // bad index
      plan.push_back(row(OP_DELETE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
                         16'hFFFF, 16'hFFFF, 1'b1, 4'hF,  1, 1, 0, 1, 0));
      // match-all allow rule
      plan.push_back(row(OP_ADD,    32'hFFFFFFFF, 32'h0,        32'hFFFFFFFF, 32'h0,        8'h00,
                         16'hFFFF, 16'h0,    1'b0, 4'hF,  1, 1, 0, 0, 1));
      plan.push_back(row(OP_CHECK,  32'hFFFFFFFF, 32'h0,        32'hFFFFFFFF, 32'h0,        8'hFF,
                         16'hFFFF, 16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_DELETE, 32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h1,  1, 1, 0, 1, 1));  // index == count
      plan.push_back(row(OP_DELETE, 32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 1, 0, 0, 0));
      // exact-match rule over the full port range
      plan.push_back(row(OP_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        32'hFFFFFFFF, 8'hFF,
                         16'h0,    16'hFFFF, 1'b0, 4'h0,  1, 1, 0, 0, 1));
      plan.push_back(row(OP_CHECK,  32'hFFFFFFFF, 32'h0,        32'h0,        32'h0,        8'hFF,
                         16'hFFFF, 16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_CHECK,  32'hFFFFFFFF, 32'h0,        32'h0,        32'h0,        8'hFE,
                         16'hFFFF, 16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_CHECK,  32'hFFFFFFFF, 32'h0,        32'h1,        32'h0,        8'hFF,
                         16'hFFFF, 16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      // inverted port range never matches
      plan.push_back(row(OP_ADD,    32'h0,        32'h0,        32'h0,        32'h0,        8'd6,
                         16'd100,  16'd50,   1'b0, 4'h0,  1, 1, 0, 0, 2));
      plan.push_back(row(OP_CHECK,  32'h0,        32'h0,        32'h0,        32'h0,        8'd6,
                         16'd75,   16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      // single-port range, probed on and either side of it
      plan.push_back(row(OP_ADD,    32'h0,        32'h0,        32'h0,        32'h0,        8'd17,
                         16'd1,    16'd1,    1'b0, 4'h0,  1, 1, 0, 0, 3));
      plan.push_back(row(OP_CHECK,  32'h0,        32'h0,        32'h0,        32'h0,        8'd17,
                         16'd1,    16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_CHECK,  32'h0,        32'h0,        32'h0,        32'h0,        8'd17,
                         16'd0,    16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_CHECK,  32'h0,        32'h0,        32'h0,        32'h0,        8'd17,
                         16'd2,    16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_FLUSH,  32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 1, 0, 0, 0));
      // fill the table: one host rule per source, verdicts alternate
      plan.push_back(row(OP_ADD,    32'h0A000000, 32'hFFFFFFFF, 32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0, 16, 0, 0, 0, 0));
      plan.push_back(row(OP_ADD,    32'h0B000000, 32'hFFFFFFFF, 32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b1, 4'h0,  1, 1, 0, 1, 16)); // table full
      plan.push_back(row(OP_CHECK,  32'h0A000003, 32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_DELETE, 32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'hF,  1, 1, 0, 0, 15)); // last slot
      plan.push_back(row(OP_DELETE, 32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'hF,  1, 1, 0, 1, 15));
      plan.push_back(row(OP_DELETE, 32'h0,        32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 1, 0, 0, 14)); // shift down
      plan.push_back(row(OP_CHECK,  32'h0A000003, 32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 0, 0, 0, 0));
      plan.push_back(row(OP_FLUSH,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
                         16'hFFFF, 16'hFFFF, 1'b1, 4'hF,  1, 1, 0, 0, 0));
      plan.push_back(row(OP_CHECK,  32'h0A000003, 32'h0,        32'h0,        32'h0,        8'h00,
                         16'h0,    16'h0,    1'b0, 4'h0,  1, 1, 1, 0, 0));

      // hold reset at first, then release it for good
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part runs with deny as the default
      program_default_verdict(1'b1);
      foreach (plan[i]) begin
         for (int r = 0; r < plan[i].reps; r++) begin
            w              = plan[i].word;
            w.src_addr     = w.src_addr + r;
            w.rule_verdict = w.rule_verdict ^ r[0];
            typed_results.push_back('{known: plan[i].known, outcome: plan[i].outcome});
            send_word(w);
         end
      end
      req_bus.valid <= 1'b0;
      wait_drained();

      // random phases; the table starts empty after the final flush above
      program_default_verdict(1'b0);
      run_random(420, 30);
      req_bus.valid <= 1'b0;
      wait_drained();

      program_default_verdict(1'b1);
      run_random(380, 20);
      req_bus.valid <= 1'b0;
      wait_drained();

      // last stretch at full rate on both sides
      calm <= 1'b1;
      program_default_verdict(1'b0);
      run_random(250, 25);
      req_bus.valid <= 1'b0;
      wait_drained();

      // let any late or extra result word show up before judging
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("first_match_packet_filter test passed");
      else
         $display("first_match_packet_filter test failed");
      $finish;
   end

endmodule

### filelist.f
src/fmpf_pkg.sv
src/fmpf_if.sv
src/fmpf_cell.sv
src/fmpf_csr.sv
src/first_match_packet_filter.sv
src/fmpf_checker.sv
sim/first_match_packet_filter_test.sv
